>>> src/sfd_pkg.sv
// Shared constants, types and functions for the subframe deframer.
// No dependencies; used by the sequencer, the datapath, the top level and the bench.
package sfd_pkg;

  localparam logic [7:0] START_MIN = 8'h81;
  localparam logic [7:0] START_MAX = 8'h84;
  localparam logic [7:0] SYNC_A    = 8'h55;
  localparam logic [7:0] SYNC_B    = 8'hAA;
  localparam logic [7:0] END_A     = 8'hEB;
  localparam logic [7:0] END_B     = 8'h90;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned SUB_LEN = 64;
  localparam int unsigned OFF_W   = $clog2(SUB_LEN);

  localparam logic [OFF_W-1:0] OFF_START  = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_FIRST  = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_SYNC_A = OFF_W'(30);
  localparam logic [OFF_W-1:0] OFF_SYNC_B = OFF_W'(31);
  localparam logic [OFF_W-1:0] OFF_REP    = OFF_W'(32);
  localparam logic [OFF_W-1:0] OFF_TAIL   = OFF_W'(33);
  localparam logic [OFF_W-1:0] OFF_END_A  = OFF_W'(62);
  localparam logic [OFF_W-1:0] OFF_LAST   = OFF_W'(63);

  localparam logic [1:0] SF_TYPE0 = 2'd0;
  localparam logic [1:0] SF_TYPE1 = 2'd1;
  localparam logic [1:0] SF_TYPE2 = 2'd2;

  typedef enum logic [1:0] {
    CU_SKIP,
    CU_DATA,
    CU_ZERO
  } crc_use_e;

  typedef struct packed {
    logic             wr;
    logic             start;
    logic             crc_en;
    logic             rd;
    logic [OFF_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic sync_ok;
    logic rep_ok;
    logic end_ok;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic crc_use_e crc_use(input logic [1:0] typ, input logic [OFF_W-1:0] off);
    logic zz;
    crc_use_e u;
    zz = off inside {[12:19], [44:51]};
    u  = CU_SKIP;
    case (typ)
      SF_TYPE0: begin
        if (off inside {[1:10], [12:29], [34:61]}) u = zz ? CU_ZERO : CU_DATA;
      end
      SF_TYPE1: begin
        if (off inside {[1:29], [33:51], [54:61]}) u = CU_DATA;
      end
      SF_TYPE2: begin
        if (off inside {[1:29], [33:59]}) u = zz ? CU_ZERO : CU_DATA;
      end
      default: begin
        if (off inside {[1:29], [33:59]}) u = CU_DATA;
      end
    endcase
    return u;
  endfunction

  // offsets of the received CRC bytes, low then high
  function automatic logic [OFF_W-1:0] rx_lo_off(input logic [1:0] typ);
    case (typ)
      SF_TYPE0: return OFF_W'(11);
      SF_TYPE1: return OFF_W'(52);
      default:  return OFF_W'(60);
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] rx_hi_off(input logic [1:0] typ);
    case (typ)
      SF_TYPE0: return OFF_W'(33);
      SF_TYPE1: return OFF_W'(53);
      default:  return OFF_W'(61);
    endcase
  endfunction

endpackage

>>> src/sfd_in_if.sv
// Input channel: one received byte per word, valid/ready handshake.
// Standalone; no package needed.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

>>> src/sfd_out_if.sv
// Output channel: one subframe byte with CRC verdict per word.
// Standalone; no package needed.
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  subframe_type;
  logic [5:0]  byte_offset;
  logic [7:0]  byte_value;
  logic        crc_ok;
  logic [15:0] crc_received;
  logic [15:0] crc_computed;
  logic        last;

  modport source (output valid, output subframe_type, output byte_offset,
                  output byte_value, output crc_ok, output crc_received,
                  output crc_computed, output last, input ready);
  modport sink   (input valid, input subframe_type, input byte_offset,
                  input byte_value, input crc_ok, input crc_received,
                  input crc_computed, input last, output ready);
endinterface

>>> src/sfd_ctrl.sv
// Sync hunt and emission sequencer for the subframe deframer.
// Depends on sfd_pkg (cmd_t, status_t, offset constants).
module sfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sfd_pkg::status_t st_i,
  output sfd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_HEAD,
    S_REP,
    S_TAIL,
    S_RD,
    S_SHOW
  } state_e;

  state_e                     state_q, state_d;
  logic [sfd_pkg::OFF_W-1:0]  cnt_q, cnt_d;
  logic                       acc;

  assign in_ready_o  = (state_q != S_RD) && (state_q != S_SHOW);
  assign out_valid_o = (state_q == S_SHOW);
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.addr    = cnt_q;
    case (state_q)
      S_HUNT: begin
        if (acc && st_i.is_start) begin
          cmd_o.wr    = 1'b1;
          cmd_o.start = 1'b1;
          cmd_o.addr  = sfd_pkg::OFF_START;
          cnt_d       = sfd_pkg::OFF_FIRST;
          state_d     = S_HEAD;
        end
      end
      S_HEAD: begin
        if (acc) begin
          cmd_o.wr     = 1'b1;
          cmd_o.crc_en = 1'b1;
          if (cnt_q == sfd_pkg::OFF_SYNC_B) begin
            if (st_i.sync_ok) begin
              cnt_d   = sfd_pkg::OFF_REP;
              state_d = S_REP;
            end else begin
              cnt_d   = sfd_pkg::OFF_START;
              state_d = S_HUNT;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_REP: begin
        if (acc) begin
          if (st_i.rep_ok) begin
            cmd_o.wr = 1'b1;
            cnt_d    = sfd_pkg::OFF_TAIL;
            state_d  = S_TAIL;
          end else if (st_i.is_start) begin
            // wrong repeat that is itself a start byte: restart on it
            cmd_o.wr    = 1'b1;
            cmd_o.start = 1'b1;
            cmd_o.addr  = sfd_pkg::OFF_START;
            cnt_d       = sfd_pkg::OFF_FIRST;
            state_d     = S_HEAD;
          end else begin
            cnt_d   = sfd_pkg::OFF_START;
            state_d = S_HUNT;
          end
        end
      end
      S_TAIL: begin
        if (acc) begin
          cmd_o.wr     = 1'b1;
          cmd_o.crc_en = 1'b1;
          if (cnt_q == sfd_pkg::OFF_LAST) begin
            cnt_d   = sfd_pkg::OFF_START;
            state_d = st_i.end_ok ? S_RD : S_HUNT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready_i) begin
          if (cnt_q == sfd_pkg::OFF_LAST) begin
            cnt_d   = sfd_pkg::OFF_START;
            state_d = S_HUNT;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: begin
        cnt_d   = sfd_pkg::OFF_START;
        state_d = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
      cnt_q   <= sfd_pkg::OFF_START;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/sfd_datapath.sv
// Subframe store, running CRC-16, sync flags and output payload.
// Depends on sfd_pkg (cmd_t, status_t, crc functions, constants).
module sfd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 data_byte_i,
  input  sfd_pkg::cmd_t              cmd_i,
  output sfd_pkg::status_t           st_o,
  output logic [1:0]                 subframe_type_o,
  output logic [sfd_pkg::OFF_W-1:0]  byte_offset_o,
  output logic [7:0]                 byte_value_o,
  output logic                       crc_ok_o,
  output logic [15:0]                crc_received_o,
  output logic [15:0]                crc_computed_o,
  output logic                       last_o
);

  logic [7:0]  mem_q [sfd_pkg::SUB_LEN];
  logic [7:0]  rd_q;
  logic [7:0]  start_q;
  logic [15:0] crc_q;
  logic [7:0]  rx_lo_q, rx_hi_q;
  logic        sync_a_q, end_a_q;
  logic [1:0]  typ;
  sfd_pkg::crc_use_e use_c;
  logic [7:0]  crc_in;

  assign typ    = 2'(start_q - sfd_pkg::START_MIN);
  assign use_c  = sfd_pkg::crc_use(typ, cmd_i.addr);
  assign crc_in = (use_c == sfd_pkg::CU_ZERO) ? 8'h00 : data_byte_i;

  assign st_o.is_start = (data_byte_i >= sfd_pkg::START_MIN) &&
                         (data_byte_i <= sfd_pkg::START_MAX);
  assign st_o.sync_ok  = sync_a_q && (data_byte_i == sfd_pkg::SYNC_B);
  assign st_o.rep_ok   = (data_byte_i == start_q);
  assign st_o.end_ok   = end_a_q && (data_byte_i == sfd_pkg::END_B);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[cmd_i.addr] <= data_byte_i;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      start_q <= data_byte_i;
    end
    if (cmd_i.wr && !cmd_i.start) begin
      if (cmd_i.addr == sfd_pkg::OFF_SYNC_A) sync_a_q <= (data_byte_i == sfd_pkg::SYNC_A);
      if (cmd_i.addr == sfd_pkg::OFF_END_A)  end_a_q  <= (data_byte_i == sfd_pkg::END_A);
      if (cmd_i.addr == sfd_pkg::rx_lo_off(typ)) rx_lo_q <= data_byte_i;
      if (cmd_i.addr == sfd_pkg::rx_hi_off(typ)) rx_hi_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= sfd_pkg::CRC_INIT;
    end else if (cmd_i.start) begin
      crc_q <= sfd_pkg::CRC_INIT;
    end else if (cmd_i.crc_en && (use_c != sfd_pkg::CU_SKIP)) begin
      crc_q <= sfd_pkg::crc_byte(crc_q, crc_in);
    end
  end

  assign subframe_type_o = typ;
  assign byte_offset_o   = cmd_i.addr;
  assign byte_value_o    = rd_q;
  assign crc_received_o  = {rx_hi_q, rx_lo_q};
  assign crc_computed_o  = crc_q;
  assign crc_ok_o        = ({rx_hi_q, rx_lo_q} == crc_q);
  assign last_o          = (cmd_i.addr == sfd_pkg::OFF_LAST);

endmodule

>>> src/subframe_sync_deframer_crc16.sv
// Subframe sync deframer with CRC-16 check: top level joining sequencer and datapath.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_ctrl, sfd_datapath.
// Input: one byte per cycle while hunting or collecting; ready is low while emitting.
// Output: after the closing byte each word is read from the store (S_RD), then held in
// the read register and offered (S_SHOW); the next word is read only once one is taken.
// Reset (async, active low): hunting, CRC at 0xFFFF; the byte store is not cleared.
module subframe_sync_deframer_crc16 (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfd_in_if.sink           in_i,
  sfd_out_if.source        out_o
);

  sfd_pkg::cmd_t    cmd;
  sfd_pkg::status_t st;

  sfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  sfd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (in_i.data_byte),
    .cmd_i           (cmd),
    .st_o            (st),
    .subframe_type_o (out_o.subframe_type),
    .byte_offset_o   (out_o.byte_offset),
    .byte_value_o    (out_o.byte_value),
    .crc_ok_o        (out_o.crc_ok),
    .crc_received_o  (out_o.crc_received),
    .crc_computed_o  (out_o.crc_computed),
    .last_o          (out_o.last)
  );

endmodule

>>> src/sfd_chk.sv
// Port-level checker for the subframe deframer, bound to the top level.
// Depends only on the top level's ports.
module sfd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  byte_offset_i,
  input logic [7:0]  byte_value_i,
  input logic        crc_ok_i,
  input logic [15:0] crc_received_i,
  input logic [15:0] crc_computed_i,
  input logic        last_i
);

  // no input taken while a word is offered
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready during emission");

  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (byte_offset_i == 6'd63)))
    else $error("last flag out of step with offset");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (crc_ok_i == (crc_received_i == crc_computed_i)))
    else $error("CRC verdict inconsistent");

  // next word follows a taken one with a gap for the store read
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> !out_valid_i ##1 out_valid_i)
    else $error("emission pacing broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_value_i))
    else $error("stalled word changed");

endmodule

bind subframe_sync_deframer_crc16 sfd_chk u_sfd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .byte_offset_i  (out_o.byte_offset),
  .byte_value_i   (out_o.byte_value),
  .crc_ok_i       (out_o.crc_ok),
  .crc_received_i (out_o.crc_received),
  .crc_computed_i (out_o.crc_computed),
  .last_i         (out_o.last)
);

>>> bench/subframe_sync_deframer_crc16_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for subframe_sync_deframer_crc16: byte streams in, subframe words out.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and the block under src.
module subframe_sync_deframer_crc16_tb;

  localparam logic [1:0] SF_TYPE3     = 2'd3;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         HOLD_CYCLES  = 500;
  localparam int         HOLD_AFTER   = 20;
  localparam int         DRAIN_CYCLES = 200;
  localparam int         MAX_PRINTS   = 30;

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_REP, PH_TAIL} sf_phase_e;

  typedef enum {FL_NONE, FL_CRC, FL_SYNC, FL_REP_START, FL_REP_OTHER, FL_END} flaw_e;

  typedef struct packed {
    logic [1:0]  sf_type;
    logic [5:0]  off;
    logic [7:0]  val;
    logic        crc_ok;
    logic [15:0] crc_rx;
    logic [15:0] crc_calc;
    logic        last;
  } sf_word_t;

  logic clk;
  logic rst_n;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  subframe_sync_deframer_crc16 dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [7:0] tx_bytes [$];
  sf_word_t   sf_expected [$];

  // deframer state as predicted
  sf_phase_e   ph;
  logic [5:0]  nxt_off;
  logic [7:0]  sf_bytes [64];
  logic [15:0] crc_acc;

  int errs       = 0;
  int words_seen = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int rx_cyc     = 0;
  int hold_left  = 0;
  bit held_once  = 0;
  int quiet      = 0;
  sf_word_t got_w;
  sf_word_t want_w;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ sfd_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic sfd_pkg::crc_use_e crc_lane(input logic [1:0] typ, input logic [5:0] off);
    int   o;
    logic blank;
    logic take;
    o     = int'(off);
    blank = (o >= 12 && o <= 19) || (o >= 44 && o <= 51);
    case (typ)
      sfd_pkg::SF_TYPE0: begin
        take = (o >= 1 && o <= 10) || (o >= 12 && o <= 29) || (o >= 34 && o <= 61);
      end
      sfd_pkg::SF_TYPE1: begin
        take  = (o >= 1 && o <= 29) || (o >= 33 && o <= 51) || (o >= 54 && o <= 61);
        blank = 1'b0;
      end
      sfd_pkg::SF_TYPE2: begin
        take = (o >= 1 && o <= 29) || (o >= 33 && o <= 59);
      end
      default: begin
        take  = (o >= 1 && o <= 29) || (o >= 33 && o <= 59);
        blank = 1'b0;
      end
    endcase
    if (!take) return sfd_pkg::CU_SKIP;
    return blank ? sfd_pkg::CU_ZERO : sfd_pkg::CU_DATA;
  endfunction

  // where the received CRC sits, low byte then high byte
  function automatic logic [5:0] crc_pos(input logic [1:0] typ, input logic hi);
    case (typ)
      sfd_pkg::SF_TYPE0: return hi ? 6'd33 : 6'd11;
      sfd_pkg::SF_TYPE1: return hi ? 6'd53 : 6'd52;
      default:           return hi ? 6'd61 : 6'd60;
    endcase
  endfunction

  task automatic stash(input logic [5:0] off, input logic [7:0] b);
    logic [7:0] d;
    sf_bytes[off] = b;
    d = sf_bytes[sfd_pkg::OFF_START] - sfd_pkg::START_MIN;
    case (crc_lane(d[1:0], off))
      sfd_pkg::CU_DATA: crc_acc = crc_step(crc_acc, b);
      sfd_pkg::CU_ZERO: crc_acc = crc_step(crc_acc, 8'h00);
      default: ;
    endcase
  endtask

  task automatic take_start(input logic [7:0] b);
    if (b >= sfd_pkg::START_MIN && b <= sfd_pkg::START_MAX) begin
      sf_bytes[sfd_pkg::OFF_START] = b;
      crc_acc = sfd_pkg::CRC_INIT;
      nxt_off = sfd_pkg::OFF_FIRST;
      ph      = PH_HEAD;
    end else begin
      nxt_off = sfd_pkg::OFF_START;
      ph      = PH_HUNT;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [5:0]  k;
    logic [7:0]  d;
    logic [1:0]  typ;
    logic [15:0] rx;
    sf_word_t    w;
    k = nxt_off;
    case (ph)
      PH_HUNT: take_start(b);
      PH_HEAD: begin
        stash(k, b);
        if (k != sfd_pkg::OFF_SYNC_B) begin
          nxt_off = k + 6'd1;
        end else if (sf_bytes[sfd_pkg::OFF_SYNC_A] == sfd_pkg::SYNC_A &&
                     sf_bytes[sfd_pkg::OFF_SYNC_B] == sfd_pkg::SYNC_B) begin
          ph      = PH_REP;
          nxt_off = sfd_pkg::OFF_REP;
        end else begin
          ph      = PH_HUNT;
          nxt_off = sfd_pkg::OFF_START;
        end
      end
      PH_REP: begin
        if (b == sf_bytes[sfd_pkg::OFF_START]) begin
          sf_bytes[sfd_pkg::OFF_REP] = b;
          nxt_off = sfd_pkg::OFF_TAIL;
          ph      = PH_TAIL;
        end else begin
          take_start(b);
        end
      end
      default: begin
        stash(k, b);
        if (k != sfd_pkg::OFF_LAST) begin
          nxt_off = k + 6'd1;
        end else begin
          ph      = PH_HUNT;
          nxt_off = sfd_pkg::OFF_START;
          if (sf_bytes[sfd_pkg::OFF_END_A] == sfd_pkg::END_A &&
              sf_bytes[sfd_pkg::OFF_LAST] == sfd_pkg::END_B) begin
            d   = sf_bytes[sfd_pkg::OFF_START] - sfd_pkg::START_MIN;
            typ = d[1:0];
            rx  = {sf_bytes[crc_pos(typ, 1'b1)], sf_bytes[crc_pos(typ, 1'b0)]};
            for (int i = 0; i < 64; i++) begin
              w.sf_type  = typ;
              w.off      = 6'(i);
              w.val      = sf_bytes[i];
              w.crc_ok   = (rx == crc_acc);
              w.crc_rx   = rx;
              w.crc_calc = crc_acc;
              w.last     = (i == 63);
              sf_expected.push_back(w);
            end
          end
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    errs++;
    if (errs <= MAX_PRINTS) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input logic [5:0] off);
    if (got !== want)
      flag_mismatch($sformatf("%s at offset %0d: got %h, want %h", name, off, got, want));
  endtask

  // builds one subframe with a correct CRC, then spoils it as asked
  task automatic queue_frame(input logic [1:0] typ, input flaw_e flaw, input int fill,
                             input bit headless, output int follow);
    logic [7:0]  fb [64];
    logic [15:0] c;
    int          len;
    follow = -1;
    len    = 64;
    fb[0]  = sfd_pkg::START_MIN + 8'(typ);
    for (int k = 1; k < 64; k++) fb[k] = (fill < 0) ? 8'($urandom) : 8'(fill);
    fb[sfd_pkg::OFF_SYNC_A] = sfd_pkg::SYNC_A;
    fb[sfd_pkg::OFF_SYNC_B] = sfd_pkg::SYNC_B;
    fb[sfd_pkg::OFF_REP]    = fb[0];
    fb[sfd_pkg::OFF_END_A]  = sfd_pkg::END_A;
    fb[sfd_pkg::OFF_LAST]   = sfd_pkg::END_B;
    c = sfd_pkg::CRC_INIT;
    for (int k = 1; k < 64; k++) begin
      case (crc_lane(typ, 6'(k)))
        sfd_pkg::CU_DATA: c = crc_step(c, fb[k]);
        sfd_pkg::CU_ZERO: c = crc_step(c, 8'h00);
        default: ;
      endcase
    end
    fb[crc_pos(typ, 1'b0)] = c[7:0];
    fb[crc_pos(typ, 1'b1)] = c[15:8];
    case (flaw)
      FL_CRC: fb[crc_pos(typ, 1'b0)] ^= 8'($urandom_range(1, 255));
      FL_SYNC: begin
        fb[30 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        len = 32;
      end
      FL_REP_START: begin
        follow = (int'(typ) + $urandom_range(1, 3)) % 4;
        fb[sfd_pkg::OFF_REP] = sfd_pkg::START_MIN + 8'(follow);
        len = 33;
      end
      FL_REP_OTHER: begin
        do fb[sfd_pkg::OFF_REP] = 8'($urandom);
        while (fb[sfd_pkg::OFF_REP] >= sfd_pkg::START_MIN &&
               fb[sfd_pkg::OFF_REP] <= sfd_pkg::START_MAX);
        len = 33;
      end
      FL_END: fb[62 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    for (int k = headless ? 1 : 0; k < len; k++) tx_bytes.push_back(fb[k]);
  endtask

  // a wrong repeat that is itself a start byte carries on as a new subframe
  task automatic queue_sequence(input logic [1:0] typ, input flaw_e flaw,
                                input flaw_e tail_flaw, input int fill);
    int follow;
    int unused;
    queue_frame(typ, flaw, fill, 1'b0, follow);
    if (follow >= 0) queue_frame(2'(follow), tail_flaw, -1, 1'b1, unused);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      ph      = PH_HUNT;
      nxt_off = sfd_pkg::OFF_START;
      crc_acc = sfd_pkg::CRC_INIT;
    end else begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.data_byte);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the word
      end else if (gap_left != 0 || tx_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= tx_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off mid-subframe
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cyc++;
      if (!held_once && out_ch.valid && words_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((rx_cyc / 97) % 3)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (rx_cyc % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      got_w = '{out_ch.subframe_type, out_ch.byte_offset, out_ch.byte_value, out_ch.crc_ok,
                out_ch.crc_received, out_ch.crc_computed, out_ch.last};
      if (sf_expected.size() == 0) begin
        flag_mismatch($sformatf("word at offset %0d with nothing expected", got_w.off));
      end else begin
        want_w = sf_expected.pop_front();
        check_field("subframe_type", got_w.sf_type, want_w.sf_type, want_w.off);
        check_field("byte_offset", got_w.off, want_w.off, want_w.off);
        check_field("byte_value", got_w.val, want_w.val, want_w.off);
        check_field("crc_ok", got_w.crc_ok, want_w.crc_ok, want_w.off);
        check_field("crc_received", got_w.crc_rx, want_w.crc_rx, want_w.off);
        check_field("crc_computed", got_w.crc_calc, want_w.crc_calc, want_w.off);
        check_field("last", got_w.last, want_w.last, want_w.off);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    flaw_e tail_fl;
    flaw_e fl;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;

    // noise at the edges of the start range, a subframe that restarts on its
    // repeat byte, then one broken header still queued during the long hold-off
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h80);
    tx_bytes.push_back(8'h85);
    tail_fl = ($urandom_range(0, 1) == 0) ? FL_NONE : FL_CRC;
    queue_sequence(2'($urandom_range(0, 3)), FL_REP_START, tail_fl, -1);
    fl = ($urandom_range(0, 1) == 0) ? FL_SYNC : FL_REP_OTHER;
    queue_sequence(2'($urandom_range(0, 3)), fl, FL_NONE, -1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (sf_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> subframe_sync_deframer_crc16.f
src/sfd_pkg.sv
src/sfd_in_if.sv
src/sfd_out_if.sv
src/sfd_ctrl.sv
src/sfd_datapath.sv
src/subframe_sync_deframer_crc16.sv
src/sfd_chk.sv
bench/subframe_sync_deframer_crc16_tb.sv
